[src/ifrl_pkg.sv]
// Shared types, codes, widths and helper functions for the IPv4 route lookup block.
`timescale 1ns / 1ps

package ifrl_pkg;

   // Field widths of the request and response items.
   localparam int OP_W      = 2;
   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 6;
   localparam int WORD_W    = 16;
   localparam int TTL_W     = 8;
   localparam int VERDICT_W = 3;
   localparam int POS_W     = 5;

   // Operation codes carried by a request.
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_WORD  = 2'd2;

   // Header word positions with a special role.
   localparam logic [POS_W-1:0] POS_TTL    = 5'd4;
   localparam logic [POS_W-1:0] POS_CKSUM  = 5'd5;
   localparam logic [POS_W-1:0] POS_DST_HI = 5'd8;
   localparam logic [POS_W-1:0] POS_DST_LO = 5'd9;
   localparam logic [POS_W-1:0] POS_MAX    = 5'd31;

   // Longest meaningful prefix length.
   localparam logic [LEN_W-1:0] MAX_PREFIX_LEN = 6'd32;

   // Response verdict codes.
   typedef enum logic [VERDICT_W-1:0] {
      V_ADDED      = 3'd0,
      V_FULL       = 3'd1,
      V_LOCAL      = 3'd2,
      V_FORWARD    = 3'd3,
      V_DROP_TTL   = 3'd4,
      V_DROP_ROUTE = 3'd5
   } verdict_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        take;
      logic        scan_first;
      logic        scan_next;
      logic        pend_load;
      verdict_type pend_verdict;
      logic        out_load;
   } ifrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_add;
      logic req_last;
      logic is_local;
      logic ttl_zero;
      logic count_zero;
      logic hit;
      logic scan_end;
      logic slot_free;
   } ifrl_status_type;

   // Network mask with the top len bits set.
   function automatic logic [ADDR_W-1:0] mask_of(input logic [LEN_W-1:0] len);
      mask_of = ~(32'hFFFF_FFFF >> len);
   endfunction

   // Ones' complement add with end-around carry.
   function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      ones_add = s[WORD_W-1:0] + WORD_W'(s[WORD_W]);
   endfunction

endpackage

[src/ifrl_if.sv]
// Valid/ready channel interfaces for requests, responses and register writes.
`timescale 1ns / 1ps

interface ifrl_req_if;
   logic                       valid;
   logic                       ready;
   logic [ifrl_pkg::OP_W-1:0]   operation;
   logic [ifrl_pkg::ADDR_W-1:0] route_prefix;
   logic [ifrl_pkg::LEN_W-1:0]  route_prefix_len;
   logic [ifrl_pkg::ADDR_W-1:0] route_hop;
   logic [ifrl_pkg::WORD_W-1:0] header_word;
   logic                       header_last;

   modport source (output valid, operation, route_prefix, route_prefix_len, route_hop,
                   header_word, header_last, input ready);
   modport sink   (input valid, operation, route_prefix, route_prefix_len, route_hop,
                   header_word, header_last, output ready);
endinterface

interface ifrl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ifrl_pkg::VERDICT_W-1:0] verdict;
   logic [ifrl_pkg::ADDR_W-1:0]    out_next_hop;
   logic [ifrl_pkg::WORD_W-1:0]    out_checksum;
   logic [ifrl_pkg::TTL_W-1:0]     out_ttl;

   modport source (output valid, verdict, out_next_hop, out_checksum, out_ttl, input ready);
   modport sink   (input valid, verdict, out_next_hop, out_checksum, out_ttl, output ready);
endinterface

interface ifrl_csr_if;
   logic                       valid;
   logic                       ready;
   logic [ifrl_pkg::ADDR_W-1:0] local_address;

   modport source (output valid, local_address, input ready);
   modport sink   (input valid, local_address, output ready);
endinterface

[src/ifrl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ifrl_ram #(
   parameter int WIDTH = 70,
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ifrl_ctrl.sv]
// Controller state machine that sequences header decisions and route table scans.
`timescale 1ns / 1ps

module ifrl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ifrl_pkg::ifrl_status_type status,
   output ifrl_pkg::ifrl_cmd_type    cmd
);

   import ifrl_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   // Requests are taken only while no decision is in progress.
   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.take = take;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (status.req_add) begin
                  state_in = ST_EMIT;
               end else if (status.req_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            priority if (status.is_local) begin
               cmd.pend_load    = 1'b1;
               cmd.pend_verdict = V_LOCAL;
               state_in         = ST_EMIT;
            end else if (status.ttl_zero) begin
               cmd.pend_load    = 1'b1;
               cmd.pend_verdict = V_DROP_TTL;
               state_in         = ST_EMIT;
            end else if (status.count_zero) begin
               cmd.pend_load    = 1'b1;
               cmd.pend_verdict = V_DROP_ROUTE;
               state_in         = ST_EMIT;
            end else begin
               cmd.scan_first = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (status.hit) begin
               cmd.pend_load    = 1'b1;
               cmd.pend_verdict = V_FORWARD;
               state_in         = ST_EMIT;
            end else if (status.scan_end) begin
               cmd.pend_load    = 1'b1;
               cmd.pend_verdict = V_DROP_ROUTE;
               state_in         = ST_EMIT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/ifrl_dp.sv]
// Datapath: route table, header accumulation, match logic and response register.
`timescale 1ns / 1ps

module ifrl_dp #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ifrl_pkg::OP_W-1:0]           req_operation,
   input  logic [ifrl_pkg::ADDR_W-1:0]         req_route_prefix,
   input  logic [ifrl_pkg::LEN_W-1:0]          req_route_prefix_len,
   input  logic [ifrl_pkg::ADDR_W-1:0]         req_route_hop,
   input  logic [ifrl_pkg::WORD_W-1:0]         req_header_word,
   input  logic                               req_header_last,
   input  logic                               csr_valid,
   input  logic [ifrl_pkg::ADDR_W-1:0]         csr_local_address,
   input  ifrl_pkg::ifrl_cmd_type              cmd,
   output ifrl_pkg::ifrl_status_type           status,
   output logic                               rsp_valid,
   output logic [ifrl_pkg::VERDICT_W-1:0]      rsp_verdict,
   output logic [ifrl_pkg::ADDR_W-1:0]         rsp_out_next_hop,
   output logic [ifrl_pkg::WORD_W-1:0]         rsp_out_checksum,
   output logic [ifrl_pkg::TTL_W-1:0]          rsp_out_ttl,
   input  logic                               rsp_ready
);

   import ifrl_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = ADDR_W + LEN_W + ADDR_W;

   logic [ADDR_W-1:0] local_addr_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [TTL_W-1:0]  ttl_ff, ttl_in;
   logic [ADDR_W-1:0] dest_ff, dest_in;
   logic [AW-1:0]     scan_idx_ff;
   verdict_type       pend_verdict_ff;
   logic [ADDR_W-1:0] pend_hop_ff;
   logic              out_valid_ff, out_valid_in;
   verdict_type       out_verdict_ff;
   logic [ADDR_W-1:0] out_hop_ff;
   logic [WORD_W-1:0] out_ck_ff;
   logic [TTL_W-1:0]  out_ttl_ff;

   logic              is_add, is_clear, is_word;
   logic              table_full;
   logic [LEN_W-1:0]  add_len;
   logic              wr_en;
   logic [EW-1:0]     wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [EW-1:0]     rd_data;
   logic [ADDR_W-1:0] ent_prefix;
   logic [LEN_W-1:0]  ent_len;
   logic [ADDR_W-1:0] ent_hop;
   logic [WORD_W-1:0] word_summed;
   logic              hdr_done;
   logic              fwd_out;

   // Request decode.
   assign is_clear = (req_operation == OP_CLEAR);
   assign is_add   = (req_operation == OP_ADD);
   assign is_word  = (req_operation == OP_WORD);

   // Route insertion: clamp the length and store the masked prefix.
   assign table_full = (count_ff == CW'(TABLE_DEPTH));
   assign add_len    = (req_route_prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                               : req_route_prefix_len;
   assign wr_en      = cmd.take && is_add && !table_full;
   assign wr_data    = {req_route_prefix & mask_of(add_len), add_len, req_route_hop};

   // Scan address: entry zero on start, then one entry per cycle.
   assign rd_en   = cmd.scan_first || cmd.scan_next;
   assign rd_addr = cmd.scan_first ? '0 : scan_idx_ff + AW'(1);

   ifrl_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_prefix = rd_data[EW-1 -: ADDR_W];
   assign ent_len    = rd_data[ADDR_W +: LEN_W];
   assign ent_hop    = rd_data[ADDR_W-1:0];

   // The TTL byte of the fifth word is summed already decremented.
   assign word_summed = (pos_ff == POS_TTL) ? {req_header_word[15:8] - 8'd1,
                                               req_header_word[7:0]}
                                            : req_header_word;

   // A header response clears the header state when it is sent.
   assign hdr_done = cmd.out_load && (pend_verdict_ff != V_ADDED)
                     && (pend_verdict_ff != V_FULL);

   // Header accumulation and table count.
   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      ttl_in   = ttl_ff;
      dest_in  = dest_ff;
      count_in = count_ff;
      if (hdr_done) begin
         pos_in  = '0;
         sum_in  = '0;
         ttl_in  = '0;
         dest_in = '0;
      end else if (cmd.take && is_word) begin
         if (pos_ff == POS_TTL) begin
            ttl_in = req_header_word[15:8];
         end else if (pos_ff == POS_DST_HI) begin
            dest_in[31:16] = req_header_word;
         end else if (pos_ff == POS_DST_LO) begin
            dest_in[15:0] = req_header_word;
         end
         if (pos_ff != POS_CKSUM) begin
            sum_in = ones_add(sum_ff, word_summed);
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
      if (cmd.take && is_clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   // Output register; it frees up in the cycle its response is taken.
   assign status.slot_free = !out_valid_ff || rsp_ready;
   assign fwd_out          = (pend_verdict_ff == V_FORWARD);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and architectural state with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         sum_ff        <= '0;
         ttl_ff        <= '0;
         dest_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            local_addr_ff <= csr_local_address;
         end
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         ttl_ff       <= ttl_in;
         dest_ff      <= dest_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Scan index, pending verdict and response payload.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         scan_idx_ff <= rd_addr;
      end
      if (cmd.take && is_add) begin
         pend_verdict_ff <= table_full ? V_FULL : V_ADDED;
         pend_hop_ff     <= '0;
      end else if (cmd.pend_load) begin
         pend_verdict_ff <= cmd.pend_verdict;
         pend_hop_ff     <= (cmd.pend_verdict == V_FORWARD) ? ent_hop : '0;
      end
      if (cmd.out_load) begin
         out_verdict_ff <= pend_verdict_ff;
         out_hop_ff     <= pend_hop_ff;
         out_ck_ff      <= fwd_out ? ~sum_ff : '0;
         out_ttl_ff     <= fwd_out ? ttl_ff - 8'd1 : '0;
      end
   end

   // Status toward the controller.
   assign status.req_add    = is_add;
   assign status.req_last   = is_word && req_header_last;
   assign status.is_local   = (dest_ff == local_addr_ff);
   assign status.ttl_zero   = (ttl_ff == '0);
   assign status.count_zero = (count_ff == '0);
   assign status.hit        = ((dest_ff & mask_of(ent_len)) == ent_prefix);
   assign status.scan_end   = ((CW'(scan_idx_ff) + CW'(1)) == count_ff);

   assign rsp_valid        = out_valid_ff;
   assign rsp_verdict      = out_verdict_ff;
   assign rsp_out_next_hop = out_hop_ff;
   assign rsp_out_checksum = out_ck_ff;
   assign rsp_out_ttl      = out_ttl_ff;

endmodule

[src/ipv4_forward_route_lookup_core.sv]
// Top level of the IPv4 forwarding decision block with its route table.
// Header words and clear requests keep the controller idle; an add visits ST_EMIT.
// A last header word visits ST_CHECK, may scan the route table one entry at a time
// through the single read port of the route table RAM, and ends in ST_EMIT.
// The response register lets a new request in while a response waits.
// Synchronous active-high reset empties the table and clears header state.
`timescale 1ns / 1ps

module ipv4_forward_route_lookup_core #(
   parameter int TABLE_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   ifrl_req_if.sink   req_if,
   ifrl_rsp_if.source rsp_if,
   ifrl_csr_if.sink   csr_if
);

   import ifrl_pkg::*;

   ifrl_cmd_type    cmd;
   ifrl_status_type status;

   // The local address register accepts a write in any cycle.
   assign csr_if.ready = 1'b1;

   ifrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ifrl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_operation        (req_if.operation),
      .req_route_prefix     (req_if.route_prefix),
      .req_route_prefix_len (req_if.route_prefix_len),
      .req_route_hop        (req_if.route_hop),
      .req_header_word      (req_if.header_word),
      .req_header_last      (req_if.header_last),
      .csr_valid            (csr_if.valid),
      .csr_local_address    (csr_if.local_address),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_if.valid),
      .rsp_verdict          (rsp_if.verdict),
      .rsp_out_next_hop     (rsp_if.out_next_hop),
      .rsp_out_checksum     (rsp_if.out_checksum),
      .rsp_out_ttl          (rsp_if.out_ttl),
      .rsp_ready            (rsp_if.ready)
   );

endmodule

[src/ifrl_checker.sv]
// Port-level checker for the route lookup core, attached by bind.
`timescale 1ns / 1ps

module ifrl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [ifrl_pkg::OP_W-1:0]          req_operation,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ifrl_pkg::VERDICT_W-1:0]     rsp_verdict,
   input logic [ifrl_pkg::ADDR_W-1:0]        rsp_out_next_hop,
   input logic [ifrl_pkg::WORD_W-1:0]        rsp_out_checksum,
   input logic [ifrl_pkg::TTL_W-1:0]         rsp_out_ttl
);

   import ifrl_pkg::*;

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_verdict) && $stable(rsp_out_next_hop)
                                  && $stable(rsp_out_checksum) && $stable(rsp_out_ttl))
      else $error("response payload changed while stalled");

   // Only a forward verdict carries next hop, checksum and TTL.
   a_non_fwd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict != V_FORWARD) |->
         (rsp_out_next_hop == '0) && (rsp_out_checksum == '0) && (rsp_out_ttl == '0))
      else $error("non-forward response carries forward fields");

   // A forwarded packet had a nonzero TTL, so the decremented one never wraps.
   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == V_FORWARD) |-> (rsp_out_ttl != 8'hFF))
      else $error("forwarded TTL wrapped");

   // An add request is answered before the next request is taken.
   a_add_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_ADD) |=> !req_ready)
      else $error("request taken while an add response is pending");

endmodule

bind ipv4_forward_route_lookup_core ifrl_checker u_ifrl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_operation    (req_if.operation),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_verdict      (rsp_if.verdict),
   .rsp_out_next_hop (rsp_if.out_next_hop),
   .rsp_out_checksum (rsp_if.out_checksum),
   .rsp_out_ttl      (rsp_if.out_ttl)
);
